// ===== design/bc1_pkg.sv =====
// Shared types, constants and field widths for the BC1 block decoder.
package bc1_pkg;

  localparam int MAX_DIMENSION_DEF = 16384;
  localparam int FIELD_LIMIT       = 16384;

  localparam int BLK_W     = 24;
  localparam int EP_W      = 16;
  localparam int IDX_W     = 32;
  localparam int COORD_W   = 14;
  localparam int CH_W      = 8;
  localparam int IMG_W_W   = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int PIX_PER_BLK = 16;
  localparam int PIX_CNT_W   = $clog2(PIX_PER_BLK);
  localparam int SEL_W       = 2;
  localparam logic [SEL_W-1:0] SEL_THIRD = 2'b11;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = BLK_W / DIV_STEP;

  // x/3 == (x*683) >> 11 for every x below 2048
  localparam int SUM_W     = 10;
  localparam int PROD_W    = 20;
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 8'd0,
    REG_OPAQUE_MODE = 8'd1
  } cfg_reg_t;

  // index 0 red, 1 green, 2 blue
  typedef logic [0:2][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [EP_W-1:0]  ea;
    logic [EP_W-1:0]  eb;
    logic [IDX_W-1:0] idx;
  } blk_data_t;

  typedef struct packed {
    rgb_t [3:0]       color;
    logic             trans3;
    logic [IDX_W-1:0] idx;
  } pal_blk_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    alpha;
    logic               oor;
    logic               last;
  } pix_t;

endpackage

// ===== design/bc1_if.sv =====
// Valid/ready channel interfaces for blocks, pixels and register writes.
interface bc1_in_if;
  import bc1_pkg::*;
  logic               valid;
  logic               ready;
  logic [BLK_W-1:0]   block_number;
  logic [EP_W-1:0]    endpoint_a;
  logic [EP_W-1:0]    endpoint_b;
  logic [IDX_W-1:0]   index_bits;

  modport source (output valid, block_number, endpoint_a, endpoint_b, index_bits,
                  input ready);
  modport sink   (input valid, block_number, endpoint_a, endpoint_b, index_bits,
                  output ready);
endinterface

interface bc1_out_if;
  import bc1_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic [CH_W-1:0]    alpha;
  logic               out_of_range;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                  out_of_range, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                  out_of_range, last, output ready);
endinterface

interface bc1_cfg_if;
  import bc1_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bc1_div_pipe.sv =====
// Pipelined restoring divider: block number by blocks-per-row, payload carried along.
module bc1_div_pipe #(
  parameter int BPR_W = 13
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [bc1_pkg::BLK_W-1:0] in_blk,
  input  bc1_pkg::blk_data_t      in_data,
  input  logic [BPR_W-1:0]        divisor,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [bc1_pkg::BLK_W-1:0] out_quo,
  output logic [BPR_W-1:0]        out_rem,
  output bc1_pkg::blk_data_t      out_data
);
  import bc1_pkg::*;

  // stage 0 captures the item, the rest resolve DIV_STEP quotient bits each
  localparam int NST = DIV_STAGES + 1;

  logic [NST-1:0]   valid_r;
  logic [NST:0]     rdy;
  logic [BLK_W-1:0] nq_r   [NST];
  logic [BLK_W-1:0] nq_nxt [NST];
  logic [BPR_W-1:0] rem_r  [NST];
  logic [BPR_W-1:0] rem_nxt[NST];
  blk_data_t        data_r [NST];

  always_comb begin
    rdy[NST] = out_ready;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = !valid_r[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[0];

  // nq holds the dividend not yet consumed above the quotient bits shifted in
  always_comb begin : div_steps
    logic [BPR_W:0]   sh;
    logic [BPR_W-1:0] rem_t;
    logic [BLK_W-1:0] nq_t;
    sh         = '0;
    nq_nxt[0]  = in_blk;
    rem_nxt[0] = '0;
    for (int s = 1; s < NST; s++) begin
      rem_t = rem_r[s-1];
      nq_t  = nq_r[s-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        sh   = {rem_t, nq_t[BLK_W-1]};
        nq_t = {nq_t[BLK_W-2:0], 1'b0};
        if (sh >= {1'b0, divisor}) begin
          sh      = sh - {1'b0, divisor};
          nq_t[0] = 1'b1;
        end
        rem_t = sh[BPR_W-1:0];
      end
      nq_nxt[s]  = nq_t;
      rem_nxt[s] = rem_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (rdy[s]) begin
          valid_r[s] <= (s == 0) ? in_valid : valid_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (rdy[s]) begin
        nq_r[s]   <= nq_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        data_r[s] <= (s == 0) ? in_data : data_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_valid = valid_r[NST-1];
  assign out_quo   = nq_r[NST-1];
  assign out_rem   = rem_r[NST-1];
  assign out_data  = data_r[NST-1];

endmodule

// ===== design/bc1_palette.sv =====
// Two-stage palette builder: endpoint expansion and sums, then thirds and mode select.
module bc1_palette #(
  parameter int BPR_W = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      opaque_mode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bc1_pkg::BLK_W-1:0] in_quo,
  input  logic [BPR_W-1:0]          in_rem,
  input  bc1_pkg::blk_data_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bc1_pkg::BLK_W-1:0] out_quo,
  output logic [BPR_W-1:0]          out_rem,
  output bc1_pkg::pal_blk_t         out_pal
);
  import bc1_pkg::*;

  function automatic rgb_t expand565(input logic [EP_W-1:0] c);
    rgb_t e;
    e[0] = {c[15:11], c[15:13]};
    e[1] = {c[10:5],  c[10:9]};
    e[2] = {c[4:0],   c[4:2]};
    return e;
  endfunction

  logic rdy_a, rdy_b;

  // stage A
  logic             a_valid_r;
  logic [BLK_W-1:0] a_quo_r;
  logic [BPR_W-1:0] a_rem_r;
  logic [IDX_W-1:0] a_idx_r;
  logic             a_four_r;
  rgb_t             a_ca_r, a_cb_r, a_mid_r;
  logic [SUM_W-1:0] a_s2_r [3];
  logic [SUM_W-1:0] a_s3_r [3];

  rgb_t             ca, cb, mid;
  logic [SUM_W-1:0] s2 [3];
  logic [SUM_W-1:0] s3 [3];
  logic [CH_W:0]    half_sum [3];
  logic             four;

  // stage B
  logic              b_valid_r;
  logic [BLK_W-1:0]  b_quo_r;
  logic [BPR_W-1:0]  b_rem_r;
  pal_blk_t          b_pal_r;
  logic [PROD_W-1:0] p2 [3];
  logic [PROD_W-1:0] p3 [3];
  pal_blk_t          pal_nxt;

  assign rdy_b    = !b_valid_r || out_ready;
  assign rdy_a    = !a_valid_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    ca   = expand565(in_data.ea);
    cb   = expand565(in_data.eb);
    four = (in_data.ea > in_data.eb) || opaque_mode;
    for (int c = 0; c < 3; c++) begin
      s2[c]       = SUM_W'({ca[c], 1'b0}) + SUM_W'(cb[c]);
      s3[c]       = SUM_W'(ca[c]) + SUM_W'({cb[c], 1'b0});
      half_sum[c] = (CH_W+1)'(ca[c]) + (CH_W+1)'(cb[c]);
      mid[c]      = half_sum[c][CH_W:1];
    end
  end

  always_comb begin
    pal_nxt.color[0] = a_ca_r;
    pal_nxt.color[1] = a_cb_r;
    pal_nxt.trans3   = !a_four_r;
    pal_nxt.idx      = a_idx_r;
    for (int c = 0; c < 3; c++) begin
      p2[c] = PROD_W'(a_s2_r[c]) * PROD_W'(RECIP3);
      p3[c] = PROD_W'(a_s3_r[c]) * PROD_W'(RECIP3);
      pal_nxt.color[2][c] = a_four_r ? CH_W'(p2[c] >> RECIP3_SH) : a_mid_r[c];
      pal_nxt.color[3][c] = a_four_r ? CH_W'(p3[c] >> RECIP3_SH) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid_r <= in_valid;
      end
      if (rdy_b) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_quo_r  <= in_quo;
      a_rem_r  <= in_rem;
      a_idx_r  <= in_data.idx;
      a_four_r <= four;
      a_ca_r   <= ca;
      a_cb_r   <= cb;
      a_mid_r  <= mid;
      for (int c = 0; c < 3; c++) begin
        a_s2_r[c] <= s2[c];
        a_s3_r[c] <= s3[c];
      end
    end
    if (rdy_b) begin
      b_quo_r <= a_quo_r;
      b_rem_r <= a_rem_r;
      b_pal_r <= pal_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_quo   = b_quo_r;
  assign out_rem   = b_rem_r;
  assign out_pal   = b_pal_r;

endmodule

// ===== design/bc1_emit.sv =====
// Pixel emitter: holds one decoded block and sends its sixteen pixels through an output register.
module bc1_emit #(
  parameter int BPR_W = 13,
  parameter int LIMIT = 16384
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bc1_pkg::BLK_W-1:0] in_quo,
  input  logic [BPR_W-1:0]          in_rem,
  input  bc1_pkg::pal_blk_t         in_pal,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bc1_pkg::pix_t             out_pix
);
  import bc1_pkg::*;

  localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(PIX_PER_BLK - 1);

  logic                 cur_valid_r;
  logic [BLK_W-1:0]     cur_quo_r;
  logic [BPR_W-1:0]     cur_rem_r;
  pal_blk_t             cur_pal_r;
  logic [PIX_CNT_W-1:0] k_r;
  logic                 out_valid_r;
  pix_t                 out_pix_r;

  logic                 emit, done, take;
  logic [SEL_W-1:0]     sel;
  logic [BLK_W+1:0]     y_full;
  logic [BPR_W+1:0]     x_full;
  pix_t                 pix_nxt;

  assign emit     = cur_valid_r && (!out_valid_r || out_ready);
  assign done     = emit && (k_r == LAST_PIX);
  assign in_ready = !cur_valid_r || done;
  assign take     = in_valid && in_ready;

  // block origin is a multiple of four, so the pixel offset fills the low bits
  always_comb begin
    sel    = cur_pal_r.idx[{k_r, 1'b0} +: SEL_W];
    y_full = {cur_quo_r, k_r[3:2]};
    x_full = {cur_rem_r, k_r[1:0]};
    pix_nxt.oor   = (y_full >= (BLK_W+2)'(LIMIT));
    pix_nxt.y     = pix_nxt.oor ? COORD_W'(LIMIT - 1) : COORD_W'(y_full);
    pix_nxt.x     = COORD_W'(x_full);
    pix_nxt.red   = cur_pal_r.color[sel][0];
    pix_nxt.green = cur_pal_r.color[sel][1];
    pix_nxt.blue  = cur_pal_r.color[sel][2];
    pix_nxt.alpha = (sel == SEL_THIRD && cur_pal_r.trans3) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    pix_nxt.last  = (k_r == LAST_PIX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cur_valid_r <= 1'b1;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end
      if (take) begin
        k_r <= '0;
      end else if (emit) begin
        k_r <= k_r + 1'b1;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= cur_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_quo_r <= in_quo;
      cur_rem_r <= in_rem;
      cur_pal_r <= in_pal;
    end
    if (emit) begin
      out_pix_r <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

// ===== design/bc1_block_decoder_core.sv =====
// BC1 block decoder: takes one 64-bit color block per item and returns its sixteen
// RGBA pixels in raster order inside the block, each with image coordinates and a
// last flag on the sixteenth. A block is accepted in any cycle the pipeline has room;
// sustained throughput is set by the result channel, which carries one pixel per
// cycle while the sink is ready, and a new block is taken while the previous one's
// pixels drain. On its way to the first pixel a block passes a capture stage, six
// divider stages that split the block number into block row and column (four
// quotient bits each), two palette stages and the emitter's block and pixel
// registers. Register writes are not held back for blocks in flight: the divider
// reads blocks-per-row at each of its stages.
module bc1_block_decoder_core #(
  parameter int MAX_DIMENSION = bc1_pkg::MAX_DIMENSION_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bc1_in_if.sink    in_ch,
  bc1_out_if.source out_ch,
  bc1_cfg_if.sink   cfg_ch
);
  import bc1_pkg::*;

  localparam int LIMIT = (MAX_DIMENSION < FIELD_LIMIT) ? MAX_DIMENSION : FIELD_LIMIT;
  localparam int BPR_W = $clog2(LIMIT / 4 + 1);

  logic [IMG_W_W-1:0] image_width_r;
  logic               opaque_mode_r;
  logic [IMG_W_W-1:0] w_base, w_clamp;
  logic [BPR_W-1:0]   divisor_r;

  blk_data_t          in_data;
  logic               div_valid, div_ready;
  logic [BLK_W-1:0]   div_quo;
  logic [BPR_W-1:0]   div_rem;
  blk_data_t          div_data;
  logic               pal_valid, pal_ready;
  logic [BLK_W-1:0]   pal_quo;
  logic [BPR_W-1:0]   pal_rem;
  pal_blk_t           pal_blk;
  pix_t               pix;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMG_W_W'(256);
      opaque_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH: image_width_r <= cfg_ch.data[IMG_W_W-1:0];
        REG_OPAQUE_MODE: opaque_mode_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // blocks per row from the width rounded down to four and clamped
  always_comb begin
    w_base = {image_width_r[IMG_W_W-1:2], 2'b00};
    if (w_base < IMG_W_W'(4)) begin
      w_clamp = IMG_W_W'(4);
    end else if (w_base > IMG_W_W'(LIMIT)) begin
      w_clamp = IMG_W_W'(LIMIT);
    end else begin
      w_clamp = w_base;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= BPR_W'(w_clamp >> 2);
  end

  assign in_data.ea  = in_ch.endpoint_a;
  assign in_data.eb  = in_ch.endpoint_b;
  assign in_data.idx = in_ch.index_bits;

  bc1_div_pipe #(.BPR_W(BPR_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_blk    (in_ch.block_number),
    .in_data   (in_data),
    .divisor   (divisor_r),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quo   (div_quo),
    .out_rem   (div_rem),
    .out_data  (div_data)
  );

  bc1_palette #(.BPR_W(BPR_W)) u_pal (
    .clk         (clk),
    .rst_n       (rst_n),
    .opaque_mode (opaque_mode_r),
    .in_valid    (div_valid),
    .in_ready    (div_ready),
    .in_quo      (div_quo),
    .in_rem      (div_rem),
    .in_data     (div_data),
    .out_valid   (pal_valid),
    .out_ready   (pal_ready),
    .out_quo     (pal_quo),
    .out_rem     (pal_rem),
    .out_pal     (pal_blk)
  );

  bc1_emit #(.BPR_W(BPR_W), .LIMIT(LIMIT)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pal_valid),
    .in_ready  (pal_ready),
    .in_quo    (pal_quo),
    .in_rem    (pal_rem),
    .in_pal    (pal_blk),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pix   (pix)
  );

  assign out_ch.pixel_x      = pix.x;
  assign out_ch.pixel_y      = pix.y;
  assign out_ch.red          = pix.red;
  assign out_ch.green        = pix.green;
  assign out_ch.blue         = pix.blue;
  assign out_ch.alpha        = pix.alpha;
  assign out_ch.out_of_range = pix.oor;
  assign out_ch.last         = pix.last;

  // divider must never see a zero or oversized blocks-per-row
  a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
    divisor_r != '0 && divisor_r <= BPR_W'(LIMIT / 4))
    else $error("blocks-per-row out of range");

  // emitter takes a block and then stays busy for its sixteen pixels
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pal_valid && pal_ready |=> !pal_ready)
    else $error("emitter took a second block at once");

  // the last pixel of a block sits in the block's rightmost column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.pixel_x[1:0] == 2'b11)
    else $error("last pixel not in rightmost block column");

endmodule
